// ===== rtl/rhsv_pkg.sv =====
// ---------------------------------------------------------------------------
// rhsv_pkg
// Shared widths, constants and types of the RGB to HSV pixel unit.
// ---------------------------------------------------------------------------
`default_nettype none

package rhsv_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int CH_MAX       = (1 << CHANNEL_BITS) - 1;

    localparam int HUE_W      = 15;
    localparam int HUE_SIXTY  = 3840;
    localparam int HUE_FULL   = 23040;
    localparam int HUE_GREEN  = 2 * HUE_SIXTY;
    localparam int HUE_BLUE   = 4 * HUE_SIXTY;

    // Quotient bits: hue quotient is at most 3840, saturation at most CH_MAX.
    localparam int QB = (CHANNEL_BITS > 12) ? CHANNEL_BITS : 12;
    // Remainder / shifted divisor width, holds both numerators.
    localparam int DW = CHANNEL_BITS + QB;

    localparam int IN_BITS     = 4 * CHANNEL_BITS;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = HUE_W + 3 * CHANNEL_BITS;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    // Two restoring divisions running side by side.
    typedef struct packed {
        logic [DW-1:0] hue_rem;
        logic [DW-1:0] hue_dsh;
        logic [QB-1:0] hue_q;
        logic [DW-1:0] sat_rem;
        logic [DW-1:0] sat_dsh;
        logic [QB-1:0] sat_q;
    } t_div;

    // Per-item data that rides along with the division.
    typedef struct packed {
        t_sector                  sector;
        logic                     neg;
        logic                     defined;
        logic                     nonblack;
        logic [CHANNEL_BITS-1:0]  max;
        logic [CHANNEL_BITS-1:0]  alpha;
    } t_side;

    typedef struct packed {
        logic [HUE_W-1:0]         hue;
        logic [CHANNEL_BITS-1:0]  saturation;
        logic [CHANNEL_BITS-1:0]  brightness;
        logic [CHANNEL_BITS-1:0]  alpha_out;
        logic                     hue_defined;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/rhsv_front.sv =====
// ---------------------------------------------------------------------------
// rhsv_front
// Entry stage: max/min, sector pick, numerators and pre-shifted divisors.
// ---------------------------------------------------------------------------
`default_nettype none

module rhsv_front
    import rhsv_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic                    i_valid,
    input  wire logic [CHANNEL_BITS-1:0] i_red,
    input  wire logic [CHANNEL_BITS-1:0] i_green,
    input  wire logic [CHANNEL_BITS-1:0] i_blue,
    input  wire logic [CHANNEL_BITS-1:0] i_alpha,
    output logic                         o_valid,
    output t_div                         o_div,
    output t_side                        o_side
);

    logic  r_valid;
    t_div  r_div,  n_div;
    t_side r_side, n_side;

    always_comb begin
        logic [CHANNEL_BITS-1:0] mx;
        logic [CHANNEL_BITS-1:0] mn;
        logic [CHANNEL_BITS-1:0] delta;
        logic [CHANNEL_BITS-1:0] p;
        logic [CHANNEL_BITS-1:0] q;
        logic [CHANNEL_BITS-1:0] mag;
        t_sector                 sec;

        mx = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue > mx)  mx = i_blue;
        mn = i_red;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn)  mn = i_blue;
        delta = mx - mn;

        // ties go red, then green
        if (i_red == mx) begin
            sec = SEC_RED;
            p   = i_green;
            q   = i_blue;
        end else if (i_green == mx) begin
            sec = SEC_GREEN;
            p   = i_blue;
            q   = i_red;
        end else begin
            sec = SEC_BLUE;
            p   = i_red;
            q   = i_green;
        end
        mag = (p < q) ? (q - p) : (p - q);

        n_div.hue_rem = DW'(mag) * DW'(HUE_SIXTY);
        n_div.hue_dsh = DW'(delta) << (QB - 1);
        n_div.hue_q   = '0;
        n_div.sat_rem = DW'(delta) * DW'(CH_MAX);
        n_div.sat_dsh = DW'(mx) << (QB - 1);
        n_div.sat_q   = '0;

        n_side.sector   = sec;
        n_side.neg      = (p < q);
        n_side.defined  = (delta != '0);
        n_side.nonblack = (mx != '0);
        n_side.max      = mx;
        n_side.alpha    = i_alpha;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div  <= n_div;
            r_side <= n_side;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// ===== rtl/rhsv_cell.sv =====
// ---------------------------------------------------------------------------
// rhsv_cell
// One divider cell: one quotient bit of both the hue and saturation division.
// ---------------------------------------------------------------------------
`default_nettype none

module rhsv_cell
    import rhsv_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_valid,
    input  wire t_div  i_div,
    input  wire t_side i_side,
    output logic       o_valid,
    output t_div       o_div,
    output t_side      o_side
);

    logic  r_valid;
    t_div  r_div,  n_div;
    t_side r_side;

    always_comb begin
        logic hue_ge;
        logic sat_ge;

        hue_ge = (i_div.hue_rem >= i_div.hue_dsh);
        sat_ge = (i_div.sat_rem >= i_div.sat_dsh);

        n_div.hue_rem = hue_ge ? (i_div.hue_rem - i_div.hue_dsh) : i_div.hue_rem;
        n_div.hue_dsh = i_div.hue_dsh >> 1;
        n_div.hue_q   = {i_div.hue_q[QB-2:0], hue_ge};
        n_div.sat_rem = sat_ge ? (i_div.sat_rem - i_div.sat_dsh) : i_div.sat_rem;
        n_div.sat_dsh = i_div.sat_dsh >> 1;
        n_div.sat_q   = {i_div.sat_q[QB-2:0], sat_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div  <= n_div;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// ===== rtl/rhsv_back.sv =====
// ---------------------------------------------------------------------------
// rhsv_back
// Final stage: sector offset, sign and wrap of hue; output register.
// ---------------------------------------------------------------------------
`default_nettype none

module rhsv_back
    import rhsv_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_valid,
    input  wire t_div  i_div,
    input  wire t_side i_side,
    output logic       o_valid,
    output t_result    o_result
);

    logic    r_valid;
    t_result r_result, n_result;

    always_comb begin
        logic [HUE_W-1:0] base;
        logic [HUE_W-1:0] qh;
        logic [HUE_W-1:0] hue;

        case (i_side.sector)
            SEC_RED:   base = '0;
            SEC_GREEN: base = HUE_W'(HUE_GREEN);
            SEC_BLUE:  base = HUE_W'(HUE_BLUE);
            default:   base = '0;
        endcase

        // hue quotient never exceeds 3840, so the low bits hold it whole
        qh = HUE_W'(i_div.hue_q);

        if (!i_side.neg) begin
            hue = base + qh;
        end else if (qh > base) begin
            // negative angle wraps by a full turn
            hue = HUE_W'(HUE_FULL) - qh + base;
        end else begin
            hue = base - qh;
        end

        n_result.hue         = i_side.defined ? hue : '0;
        n_result.saturation  = i_side.nonblack ? CHANNEL_BITS'(i_div.sat_q) : '0;
        n_result.brightness  = i_side.max;
        n_result.alpha_out   = i_side.alpha;
        n_result.hue_defined = i_side.defined;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== rtl/rgb_to_hsv_pixel_unit.sv =====
// ---------------------------------------------------------------------------
// rgb_to_hsv_pixel_unit
// RGB plus alpha to hue / saturation / value, one pixel per clock when not stalled.
// ---------------------------------------------------------------------------
// The unit takes one pixel item on every clock in which s_axis_tready is high
// and raises m_axis_tvalid with its result after it passes one entry stage, a
// chain of QB divider cells that each settle one quotient bit of the hue and
// saturation divisions, and the output register, all loaded one after the other.
// The whole chain advances together whenever the output register is empty or
// being taken, so the sustained rate is one item per clock; a stall on
// m_axis_tready holds every stage and drops s_axis_tready in the same cycle.
// Hue is in 1/64 degree (0..23039); m_axis_tuser is low for black and grey
// pixels, for which hue reads 0.
`default_nettype none

module rgb_to_hsv_pixel_unit
    import rhsv_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // red, green, blue, alpha_in
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // hue, saturation, brightness, alpha_out
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // hue_defined
    output logic                        m_axis_tuser
);

    logic    w_en;
    logic    w_valid [QB+1];
    t_div    w_div   [QB+1];
    t_side   w_side  [QB+1];
    t_result w_result;

    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    rhsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_red   (s_axis_tdata[CHANNEL_BITS-1:0]),
        .i_green (s_axis_tdata[2*CHANNEL_BITS-1:CHANNEL_BITS]),
        .i_blue  (s_axis_tdata[3*CHANNEL_BITS-1:2*CHANNEL_BITS]),
        .i_alpha (s_axis_tdata[4*CHANNEL_BITS-1:3*CHANNEL_BITS]),
        .o_valid (w_valid[0]),
        .o_div   (w_div[0]),
        .o_side  (w_side[0])
    );

    for (genvar k = 0; k < QB; k++) begin : g_cell
        rhsv_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[k]),
            .i_div   (w_div[k]),
            .i_side  (w_side[k]),
            .o_valid (w_valid[k+1]),
            .o_div   (w_div[k+1]),
            .o_side  (w_side[k+1])
        );
    end

    rhsv_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_valid[QB]),
        .i_div    (w_div[QB]),
        .i_side   (w_side[QB]),
        .o_valid  (m_axis_tvalid),
        .o_result (w_result)
    );

    assign m_axis_tdata = OUT_TDATA_W'({w_result.alpha_out, w_result.brightness,
                                        w_result.saturation, w_result.hue});
    assign m_axis_tuser = w_result.hue_defined;

endmodule

`default_nettype wire

// ===== rtl/rhsv_checker.sv =====
// ---------------------------------------------------------------------------
// rhsv_checker
// Port-level checks of the RGB to HSV pixel unit, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module rhsv_checker
    import rhsv_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                   m_axis_tuser
);

    logic [HUE_W-1:0]        w_hue;
    logic [CHANNEL_BITS-1:0] w_sat;
    logic [CHANNEL_BITS-1:0] w_bright;

    assign w_hue    = m_axis_tdata[HUE_W-1:0];
    assign w_sat    = m_axis_tdata[HUE_W+CHANNEL_BITS-1:HUE_W];
    assign w_bright = m_axis_tdata[HUE_W+2*CHANNEL_BITS-1:HUE_W+CHANNEL_BITS];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("stalled item changed");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input held off with the output empty");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> w_hue < HUE_W'(HUE_FULL))
        else $error("hue beyond a full turn");

    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> w_hue == '0 && w_sat == '0)
        else $error("grey or black item with nonzero hue or saturation");

    a_def_chroma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> w_sat != '0 && w_bright != '0)
        else $error("item with defined hue but no chroma");

endmodule

bind rgb_to_hsv_pixel_unit rhsv_checker u_rhsv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== tb/tb_rgb_to_hsv_pixel_unit.sv =====
// ---------------------------------------------------------------------------
// tb_rgb_to_hsv_pixel_unit
// Self-checking bench for the RGB to HSV pixel unit. A directed table covers
// black, grey, primaries, ties for the maximum and negative hue wrap. Random
// pixels follow, biased toward grey, tie and extreme channel values. Both
// stream sides idle at random, and one long output stall fills the pipeline.
// Results are checked field by field against the table or an in-bench predictor.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_rgb_to_hsv_pixel_unit;
    import rhsv_pkg::*;

    localparam int N_RANDOM   = 400;
    localparam int HOLD_OFF   = 300;   // long output stall, in cycles
    localparam int HOLD_AT    = 60;    // results seen before the long stall
    localparam int DRAIN_WAIT = 40;

    typedef logic [CHANNEL_BITS-1:0] t_chan;

    typedef struct packed {
        t_chan   r;
        t_chan   g;
        t_chan   b;
        t_chan   a;
        logic    fixed;
        t_result want;
    } t_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // red, green, blue, alpha_in
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // hue, saturation, brightness, alpha_out
    logic                   m_axis_tuser;   // hue_defined

    t_result hsv_due_q[$];
    t_row    dir_rows[$];
    int      bad_cnt;
    int      shown_cnt;
    int      out_cnt;
    bit      tx_calm;

    rgb_to_hsv_pixel_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Expected hue / saturation / value of one pixel.
    function automatic t_result hsv_of_pixel(input t_chan r, input t_chan g,
                                             input t_chan b, input t_chan a);
        int      ri;
        int      gi;
        int      bi;
        int      mx;
        int      mn;
        int      delta;
        int      diff;
        int      base;
        int      h;
        t_result res;
        ri = r;
        gi = g;
        bi = b;
        mx = ri;
        if (gi > mx) mx = gi;
        if (bi > mx) mx = bi;
        mn = ri;
        if (gi < mn) mn = gi;
        if (bi < mn) mn = bi;
        delta = mx - mn;
        res = '0;
        res.brightness = t_chan'(mx);
        res.alpha_out  = a;
        if (mx != 0)
            res.saturation = t_chan'((CH_MAX * delta) / mx);
        if (delta != 0) begin
            // ties resolve red, then green, then blue
            if (ri == mx) begin
                diff = gi - bi;
                base = 0;
            end else if (gi == mx) begin
                diff = bi - ri;
                base = HUE_GREEN;
            end else begin
                diff = ri - gi;
                base = HUE_BLUE;
            end
            h = base + (diff * HUE_SIXTY) / delta;   // truncates toward zero
            if (h < 0) h += HUE_FULL;
            res.hue         = h[HUE_W-1:0];
            res.hue_defined = 1'b1;
        end
        return res;
    endfunction

    function automatic int idle_len(input bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_row(input t_chan r, input t_chan g, input t_chan b,
                           input t_chan a, input logic fixed,
                           input int hue, input int sat, input int bri,
                           input logic defd);
        t_row row;
        row.r                = r;
        row.g                = g;
        row.b                = b;
        row.a                = a;
        row.fixed            = fixed;
        row.want.hue         = hue[HUE_W-1:0];
        row.want.saturation  = t_chan'(sat);
        row.want.brightness  = t_chan'(bri);
        row.want.alpha_out   = a;
        row.want.hue_defined = defd;
        dir_rows.push_back(row);
    endtask

    task automatic send_pixel(input t_chan r, input t_chan g, input t_chan b,
                              input t_chan a, input t_result want);
        int gap;
        gap = idle_len(tx_calm);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {a, b, g, r};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        hsv_due_q.push_back(want);
    endtask

    task automatic check_result(input logic [OUT_TDATA_W-1:0] data,
                                input logic defd);
        t_result got;
        t_result want;
        got.hue         = data[HUE_W-1:0];
        got.saturation  = data[HUE_W +: CHANNEL_BITS];
        got.brightness  = data[HUE_W+CHANNEL_BITS +: CHANNEL_BITS];
        got.alpha_out   = data[HUE_W+2*CHANNEL_BITS +: CHANNEL_BITS];
        got.hue_defined = defd;
        out_cnt++;
        if (hsv_due_q.size() == 0) begin
            bad_cnt++;
            if (shown_cnt < 10) begin
                shown_cnt++;
                $display("unexpected result: hue %0d sat %0d val %0d alpha %0d def %0b",
                         got.hue, got.saturation, got.brightness, got.alpha_out,
                         got.hue_defined);
            end
        end else begin
            want = hsv_due_q.pop_front();
            if (got.hue !== want.hue || got.saturation !== want.saturation ||
                got.brightness !== want.brightness ||
                got.alpha_out !== want.alpha_out ||
                got.hue_defined !== want.hue_defined) begin
                bad_cnt++;
                if (shown_cnt < 10) begin
                    shown_cnt++;
                    $display("result %0d: expected hue %0d sat %0d val %0d alpha %0d def %0b",
                             out_cnt, want.hue, want.saturation, want.brightness,
                             want.alpha_out, want.hue_defined);
                    $display("result %0d: got      hue %0d sat %0d val %0d alpha %0d def %0b",
                             out_cnt, got.hue, got.saturation, got.brightness,
                             got.alpha_out, got.hue_defined);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            check_result(m_axis_tdata, m_axis_tuser);
    end

    // Output side: random back-pressure, calm stretches, one long hold-off.
    initial begin : rx_side
        int  gap;
        int  turns;
        bit  held;
        bit  rx_calm;
        m_axis_tready = 1'b0;
        held    = 1'b0;
        rx_calm = 1'b0;
        turns   = 0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (!held && out_cnt >= HOLD_AT) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF) @(negedge i_clk);
            end else begin
                if (turns % 64 == 0) rx_calm = ($urandom_range(0, 2) == 0);
                turns++;
                gap = idle_len(rx_calm);
                if (gap > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
                m_axis_tready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    // Input side: directed table, then random pixels.
    initial begin : tx_side
        t_row    row;
        t_result want;
        t_chan   r;
        t_chan   g;
        t_chan   b;
        t_chan   a;
        t_chan   m;
        t_chan   lo;
        int      kind;
        bad_cnt       = 0;
        shown_cnt     = 0;
        out_cnt       = 0;
        tx_calm       = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        //        r    g    b    a    fixed hue    sat  val  def
        add_row(  0,   0,   0,   0, 1'b1,     0,   0,   0, 1'b0);  // black
        add_row(  0,   0,   0, 255, 1'b1,     0,   0,   0, 1'b0);
        add_row(255, 255, 255,   0, 1'b1,     0,   0, 255, 1'b0);  // white
        add_row(128, 128, 128, 170, 1'b1,     0,   0, 128, 1'b0);  // grey
        add_row(255,   0,   0,  85, 1'b1,     0, 255, 255, 1'b1);
        add_row(  0, 255,   0, 255, 1'b1,  7680, 255, 255, 1'b1);
        add_row(  0,   0, 255,  17, 1'b1, 15360, 255, 255, 1'b1);
        add_row(255, 255,   0,   1, 1'b1,  3840, 255, 255, 1'b1);  // red wins tie
        add_row(  0, 255, 255, 254, 1'b1, 11520, 255, 255, 1'b1);  // green wins tie
        add_row(255,   0, 255, 128, 1'b1, 19200, 255, 255, 1'b1);  // wraps negative
        add_row(  1,   0,   0,  64, 1'b1,     0, 255,   1, 1'b1);
        add_row(255,   0,   1,   2, 1'b0,     0,   0,   0, 1'b0);
        add_row(  1,   1,   0,   3, 1'b0,     0,   0,   0, 1'b0);
        add_row(200, 100,  50,   4, 1'b0,     0,   0,   0, 1'b0);
        add_row( 50, 200, 100,   5, 1'b0,     0,   0,   0, 1'b0);
        add_row(100,  50, 200,   6, 1'b0,     0,   0,   0, 1'b0);
        add_row( 10, 255, 254,   7, 1'b0,     0,   0,   0, 1'b0);
        add_row(254, 255,   0,   8, 1'b0,     0,   0,   0, 1'b0);
        add_row( 85, 170,  85, 170, 1'b0,     0,   0,   0, 1'b0);
        add_row(170,  85, 170,  85, 1'b0,     0,   0,   0, 1'b0);
        add_row(  1,   2,   3,   9, 1'b0,     0,   0,   0, 1'b0);
        add_row(255, 254, 253, 250, 1'b0,     0,   0,   0, 1'b0);
        add_row(  3, 200,   3, 100, 1'b0,     0,   0,   0, 1'b0);

        foreach (dir_rows[i]) begin
            row  = dir_rows[i];
            want = row.fixed ? row.want : hsv_of_pixel(row.r, row.g, row.b, row.a);
            send_pixel(row.r, row.g, row.b, row.a, want);
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 40 == 0) tx_calm = ($urandom_range(0, 2) == 0);
            kind = $urandom_range(0, 9);
            r = t_chan'($urandom);
            g = t_chan'($urandom);
            b = t_chan'($urandom);
            a = t_chan'($urandom);
            if (kind == 0) begin
                // grey, occasionally black
                if ($urandom_range(0, 3) == 0) r = '0;
                g = r;
                b = r;
            end else if (kind <= 2) begin
                // two channels share the maximum
                m  = t_chan'($urandom);
                lo = t_chan'($urandom_range(0, m));
                case ($urandom_range(0, 2))
                    0: begin r = m; g = m; b = lo; end
                    1: begin g = m; b = m; r = lo; end
                    default: begin r = m; b = m; g = lo; end
                endcase
            end else if (kind <= 4) begin
                // channels pinned to the ends of the range
                if ($urandom_range(0, 1)) r = ($urandom_range(0, 1)) ? t_chan'(CH_MAX) : '0;
                if ($urandom_range(0, 1)) g = ($urandom_range(0, 1)) ? t_chan'(CH_MAX) : '0;
                if ($urandom_range(0, 1)) b = ($urandom_range(0, 1)) ? t_chan'(CH_MAX) : '0;
            end
            send_pixel(r, g, b, a, hsv_of_pixel(r, g, b, a));
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (hsv_due_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (bad_cnt == 0) begin
            $display("tb_rgb_to_hsv_pixel_unit passed");
        end else begin
            $display("tb_rgb_to_hsv_pixel_unit failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(20 * 1_000_000);
        $display("tb_rgb_to_hsv_pixel_unit failed");
        $finish;
    end

endmodule

`default_nettype wire
